### sv/ccde_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the character canvas draw engine.
// No dependencies; imported by ccde_front, ccde_queue, ccde_back and the top level.
package ccde_pkg;

  // Input action codes
  localparam logic [2:0] ACT_POINT = 3'd0;
  localparam logic [2:0] ACT_HLINE = 3'd1;
  localparam logic [2:0] ACT_VLINE = 3'd2;
  localparam logic [2:0] ACT_RECT  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;
  localparam logic [2:0] ACT_READ  = 3'd5;

  // Configuration register indexes
  localparam int          CFG_IDX_W         = 2;
  localparam logic [1:0]  REG_ACTIVE_WIDTH  = 2'd0;
  localparam logic [1:0]  REG_ACTIVE_HEIGHT = 2'd1;
  localparam logic [7:0]  ACTIVE_RESET      = 8'd128;

  localparam logic [7:0] BLANK_CHAR = 8'h20;

  // Cell coordinates inside the engine: 7-bit start plus up to 254 of offset
  localparam int COORD_W = 9;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef enum logic [2:0] {
    CMD_HLINE,
    CMD_VLINE,
    CMD_RECT,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_t;

  // Decoded command; x_last / y_last are extents minus one
  typedef struct packed {
    cmd_kind_t  kind;
    logic [6:0] col;
    logic [6:0] row;
    logic [7:0] x_last;
    logic [7:0] y_last;
    logic [7:0] ch;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_LINE,
    BK_CLEAR,
    BK_READ
  } back_state_t;

  typedef enum logic [1:0] {
    PH_TOP,
    PH_BOTTOM,
    PH_LEFT,
    PH_RIGHT
  } phase_t;

endpackage

### sv/ccde_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ccde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/ccde_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, item accept and command decode.
// Depends on ccde_pkg.
module ccde_front import ccde_pkg::*; #(
  parameter int CANVAS_SIZE = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           action,
  input  logic [6:0]           col,
  input  logic [6:0]           row,
  input  logic [7:0]           span_x,
  input  logic [7:0]           span_y,
  input  logic [7:0]           fill_char,
  input  logic                 init_busy,
  input  logic                 q_full,
  output logic                 push,
  output cmd_t                 push_cmd
);

  logic [7:0]         active_width;
  logic [7:0]         active_height;
  logic [COORD_W-1:0] clr_w;
  logic [COORD_W-1:0] clr_h;
  logic               keep;
  logic               accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = rst | init_busy | q_full;
  assign accept    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_width  <= ACTIVE_RESET;
      active_height <= ACTIVE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ACTIVE_WIDTH) begin
        active_width <= cfg_data;
      end else if (cfg_index == REG_ACTIVE_HEIGHT) begin
        active_height <= cfg_data;
      end
    end
  end

  // clear region bounded by the physical canvas
  always_comb begin
    clr_w = ({1'b0, active_width} < COORD_W'(CANVAS_SIZE)) ?
            {1'b0, active_width} : COORD_W'(CANVAS_SIZE);
    clr_h = ({1'b0, active_height} < COORD_W'(CANVAS_SIZE)) ?
            {1'b0, active_height} : COORD_W'(CANVAS_SIZE);
  end

  always_comb begin
    push_cmd.kind   = CMD_HLINE;
    push_cmd.col    = col;
    push_cmd.row    = row;
    push_cmd.x_last = span_x - 8'd1;
    push_cmd.y_last = span_y - 8'd1;
    push_cmd.ch     = fill_char;
    keep            = 1'b0;
    case (action)
      ACT_POINT: begin
        push_cmd.x_last = 8'd0;
        keep            = 1'b1;
      end
      ACT_HLINE: begin
        keep = (span_x != 8'd0);
      end
      ACT_VLINE: begin
        push_cmd.kind = CMD_VLINE;
        keep          = (span_y != 8'd0);
      end
      ACT_RECT: begin
        push_cmd.kind = CMD_RECT;
        keep          = (span_x != 8'd0) && (span_y != 8'd0);
      end
      ACT_CLEAR: begin
        push_cmd.kind   = CMD_CLEAR;
        push_cmd.x_last = 8'(clr_w - COORD_W'(1));
        push_cmd.y_last = 8'(clr_h - COORD_W'(1));
        keep            = (clr_w != '0) && (clr_h != '0);
      end
      ACT_READ: begin
        push_cmd.kind = CMD_READ;
        keep          = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // empty drawings and unused actions are taken and dropped here
  assign push = accept & keep;

endmodule

### sv/ccde_queue.sv
`timescale 1ns / 1ps
// Two-entry command queue between the front end and the draw sequencer.
// Depends on ccde_pkg.
module ccde_queue import ccde_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t q_cmd
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

### sv/ccde_back.sv
`timescale 1ns / 1ps
// Draw sequencer: walks lines, rectangle edges and clear regions one cell
// per cycle into the canvas RAM and serves reads. Depends on ccde_pkg, ccde_ram.
module ccde_back import ccde_pkg::*; #(
  parameter int CANVAS_SIZE = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       pop,
  output logic       init_busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] cell_char
);

  localparam int DEPTH = CANVAS_SIZE * CANVAS_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(CANVAS_SIZE);

  back_state_t state, state_next;
  phase_t      phase, phase_next;
  logic [7:0]  cnt_i, cnt_i_next;
  logic [7:0]  cnt_j, cnt_j_next;
  logic [7:0]  x_last, x_last_next;
  logic [7:0]  y_last, y_last_next;
  logic [6:0]  base_x, base_x_next;
  logic [6:0]  base_y, base_y_next;
  logic [7:0]  ch, ch_next;
  logic        rect, rect_next;
  logic        oob, oob_next;

  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic [COORD_W-1:0] rx;
  logic [COORD_W-1:0] ry;
  logic [7:0]         len_last;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [7:0]         wdata;
  logic               re;
  logic [AW-1:0]      raddr;
  logic [7:0]         rdata;

  function automatic logic [AW-1:0] addr_of(input logic [COORD_W-1:0] x,
                                            input logic [COORD_W-1:0] y);
    addr_of = AW'(AW'(y[CW-1:0]) * AW'(CANVAS_SIZE)) + AW'(x[CW-1:0]);
  endfunction

  function automatic logic on_canvas(input logic [COORD_W-1:0] x,
                                     input logic [COORD_W-1:0] y);
    on_canvas = (x < COORD_W'(CANVAS_SIZE)) && (y < COORD_W'(CANVAS_SIZE));
  endfunction

  ccde_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign init_busy = (state == BK_INIT);

  // current cell of the walk
  always_comb begin
    len_last = 8'd0;
    cx       = {1'b0, cnt_i};
    cy       = {1'b0, cnt_j};
    if (state == BK_LINE) begin
      case (phase)
        PH_TOP: begin
          cx       = {2'b0, base_x} + {1'b0, cnt_i};
          cy       = {2'b0, base_y};
          len_last = x_last;
        end
        PH_BOTTOM: begin
          cx       = {2'b0, base_x} + {1'b0, cnt_i};
          cy       = {2'b0, base_y} + {1'b0, y_last};
          len_last = x_last;
        end
        PH_LEFT: begin
          cx       = {2'b0, base_x};
          cy       = {2'b0, base_y} + {1'b0, cnt_i};
          len_last = y_last;
        end
        PH_RIGHT: begin
          cx       = {2'b0, base_x} + {1'b0, x_last};
          cy       = {2'b0, base_y} + {1'b0, cnt_i};
          len_last = y_last;
        end
        default: begin
          len_last = x_last;
        end
      endcase
    end
  end

  assign rx    = {2'b0, q_cmd.col};
  assign ry    = {2'b0, q_cmd.row};
  assign waddr = addr_of(cx, cy);
  assign raddr = addr_of(rx, ry);

  always_comb begin
    state_next  = state;
    phase_next  = phase;
    cnt_i_next  = cnt_i;
    cnt_j_next  = cnt_j;
    x_last_next = x_last;
    y_last_next = y_last;
    base_x_next = base_x;
    base_y_next = base_y;
    ch_next     = ch;
    rect_next   = rect;
    oob_next    = oob;
    pop         = 1'b0;
    we          = 1'b0;
    wdata       = BLANK_CHAR;
    re          = 1'b0;
    case (state)
      BK_INIT, BK_CLEAR: begin
        we = 1'b1;
        if (cnt_i == x_last) begin
          cnt_i_next = 8'd0;
          if (cnt_j == y_last) begin
            state_next = BK_IDLE;
          end else begin
            cnt_j_next = cnt_j + 8'd1;
          end
        end else begin
          cnt_i_next = cnt_i + 8'd1;
        end
      end
      BK_LINE: begin
        we    = on_canvas(cx, cy);
        wdata = ch;
        if (cnt_i == len_last) begin
          cnt_i_next = 8'd0;
          if (rect && phase != PH_RIGHT) begin
            phase_next = phase_t'(phase + 2'd1);
          end else begin
            state_next = BK_IDLE;
          end
        end else begin
          cnt_i_next = cnt_i + 8'd1;
        end
      end
      BK_READ: begin
        state_next = BK_IDLE;
      end
      BK_IDLE: begin
        // a read waits until the output register is free
        if (q_valid && !(q_cmd.kind == CMD_READ && out_valid)) begin
          pop         = 1'b1;
          cnt_i_next  = 8'd0;
          cnt_j_next  = 8'd0;
          x_last_next = q_cmd.x_last;
          y_last_next = q_cmd.y_last;
          base_x_next = q_cmd.col;
          base_y_next = q_cmd.row;
          ch_next     = q_cmd.ch;
          rect_next   = 1'b0;
          case (q_cmd.kind)
            CMD_HLINE: begin
              phase_next = PH_TOP;
              state_next = BK_LINE;
            end
            CMD_VLINE: begin
              phase_next = PH_LEFT;
              state_next = BK_LINE;
            end
            CMD_RECT: begin
              phase_next = PH_TOP;
              rect_next  = 1'b1;
              state_next = BK_LINE;
            end
            CMD_CLEAR: begin
              state_next = BK_CLEAR;
            end
            CMD_READ: begin
              re         = 1'b1;
              oob_next   = ~on_canvas(rx, ry);
              state_next = BK_READ;
            end
            default: begin
              state_next = BK_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= BK_INIT;
      phase  <= PH_TOP;
      cnt_i  <= 8'd0;
      cnt_j  <= 8'd0;
      x_last <= 8'(CANVAS_SIZE - 1);
      y_last <= 8'(CANVAS_SIZE - 1);
      rect   <= 1'b0;
    end else begin
      state  <= state_next;
      phase  <= phase_next;
      cnt_i  <= cnt_i_next;
      cnt_j  <= cnt_j_next;
      x_last <= x_last_next;
      y_last <= y_last_next;
      rect   <= rect_next;
    end
  end

  always_ff @(posedge clk) begin
    base_x <= base_x_next;
    base_y <= base_y_next;
    ch     <= ch_next;
    oob    <= oob_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == BK_READ) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_READ) begin
      cell_char <= oob ? BLANK_CHAR : rdata;
    end
  end

endmodule

### sv/char_canvas_draw_engine_top.sv
`timescale 1ns / 1ps
// Character canvas draw engine, top level. Holds a CANVAS_SIZE x CANVAS_SIZE
// byte canvas in one RAM; drawing takes one cell per cycle through its single
// write port. After reset the whole canvas is swept to spaces with in_stall
// high; configuration writes are taken meanwhile. A clear blanks an
// active_width x active_height region from the origin, bounded by CANVAS_SIZE;
// a read waits for the output register to empty. Empty drawings and unused
// actions never reach the sequencer.
// A two-entry queue lets the next items be accepted while a long command runs.
// Cells outside the canvas are clipped; a read outside it returns a space.
// Depends on ccde_pkg, ccde_front, ccde_queue, ccde_back, ccde_ram.
module char_canvas_draw_engine_top import ccde_pkg::*; #(
  parameter int CANVAS_SIZE = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           action,
  input  logic [6:0]           col,
  input  logic [6:0]           row,
  input  logic [7:0]           span_x,
  input  logic [7:0]           span_y,
  input  logic [7:0]           fill_char,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           cell_char
);

  logic init_busy;
  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_valid;
  cmd_t q_cmd;

  ccde_front #(
    .CANVAS_SIZE (CANVAS_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .col       (col),
    .row       (row),
    .span_x    (span_x),
    .span_y    (span_y),
    .fill_char (fill_char),
    .init_busy (init_busy),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  ccde_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  ccde_back #(
    .CANVAS_SIZE (CANVAS_SIZE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cell_char (cell_char)
  );

endmodule
